@@ sv/rcsr_pkg.sv @@
// Shared constants, register indices and reset values for the RV64 CSR file.
`default_nettype none
package rcsr_pkg;

  localparam int XLEN         = 64;
  localparam int IDX_W        = 7;
  localparam int HART_W       = 12;
  localparam int NUM_REGS_DEF = 119;
  localparam int CFG_AW       = 3;
  localparam int CFG_DW       = 32;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [XLEN-1:0]  xword_t;
  typedef logic [1:0]       prv_t;

  // configuration register select (paddr[2])
  localparam logic CFG_HART_ID = 1'b0;

  // privilege codes held in the PRV shadow
  localparam prv_t PRV_U = 2'd0;
  localparam prv_t PRV_S = 2'd1;
  localparam prv_t PRV_X = 2'd2;
  localparam prv_t PRV_M = 2'd3;

  localparam idx_t R_PRV        = 7'd0;
  localparam idx_t R_ISA        = 7'd1;
  localparam idx_t R_HARTID     = 7'd5;
  localparam idx_t R_STATUS     = 7'd6;
  localparam idx_t R_IP         = 7'd7;
  localparam idx_t R_IE         = 7'd8;
  localparam idx_t R_CYCLE      = 7'd9;
  localparam idx_t R_TIME       = 7'd10;
  localparam idx_t R_INSTRET    = 7'd11;
  localparam idx_t R_HPM_LAST   = 7'd40;
  localparam idx_t R_TSELECT    = 7'd70;
  localparam idx_t R_MCOUNTEREN = 7'd80;
  localparam idx_t R_MEPC       = 7'd82;
  localparam idx_t R_SCOUNTEREN = 7'd106;
  localparam idx_t R_SEPC       = 7'd108;
  localparam idx_t R_SATP       = 7'd111;

  localparam xword_t PRV_RST     = 64'h3;
  localparam xword_t ISA_RST     = (64'h2 << 62) | 64'h14112D;
  localparam xword_t STATUS_RST  = (64'h2 << 32) | (64'h2 << 34) | (64'h1 << 13);
  localparam xword_t CNTEN_RST   = 64'h7;
  localparam xword_t TSELECT_RST = 64'h1;

  localparam logic [3:0] XL_FIXED  = 4'hA;
  localparam logic [3:0] SATP_BARE = 4'h0;
  localparam logic [3:0] SATP_SV39 = 4'h8;
  localparam int         EXT_C     = 2;

  function automatic xword_t rst_val(input idx_t idx);
    xword_t v;
    v = '0;
    unique case (idx)
      R_PRV:        v = PRV_RST;
      R_ISA:        v = ISA_RST;
      R_STATUS:     v = STATUS_RST;
      R_MCOUNTEREN: v = CNTEN_RST;
      R_SCOUNTEREN: v = CNTEN_RST;
      R_TSELECT:    v = TSELECT_RST;
      default:      v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ sv/rcsr_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module rcsr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ sv/riscv_csr_register_file.sv @@
// RV64 control and status register file: top level.
// One access word enters per cycle while out_ready stays high; its result
// word passes the stage-1 register and then leaves from the result register.
// The storage is a single RAM with registered read; the write value and all
// privilege, counter-enable and EPC decisions are settled at acceptance from
// small shadow registers, so an access sees every earlier write. Entries never
// written read as their architected reset value via per-entry valid flags,
// so no clearing pass is needed after reset. Counter, IP, IE and hart id
// reads come from the input word or the hart_id register, not the RAM.
`default_nettype none
module riscv_csr_register_file #(
  parameter int NUM_REGS = rcsr_pkg::NUM_REGS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic                        in_action,
  input  wire logic [rcsr_pkg::IDX_W-1:0]  in_reg_index,
  input  wire logic [63:0]                 in_write_data,
  input  wire logic [63:0]                 in_cycle_count,
  input  wire logic [63:0]                 in_retired_count,
  input  wire logic [63:0]                 in_wall_time,
  input  wire logic [63:0]                 in_pending_ints,
  input  wire logic [63:0]                 in_enabled_ints,
  input  wire logic [1:0]                  in_next_pc_low,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [63:0]                      out_read_data,
  output logic                             out_illegal_index,
  output logic                             out_pending_write,
  output logic                             out_enable_write,
  output logic [63:0]                      out_forward_data,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [rcsr_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [rcsr_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [rcsr_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                             cfg_pready
);

  localparam int AW = $clog2(NUM_REGS);

  // configuration
  logic [rcsr_pkg::HART_W-1:0] hart_id_r;
  logic                        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hart_id_r <= '0;
    end else if (cfg_wr && (cfg_paddr[2] == rcsr_pkg::CFG_HART_ID)) begin
      hart_id_r <= cfg_pwdata[rcsr_pkg::HART_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == rcsr_pkg::CFG_HART_ID) begin
      cfg_prdata = rcsr_pkg::CFG_DW'(hart_id_r);
    end
  end

  // handshake
  logic s1_vld_r;
  logic out_vld_r;
  logic s1_adv;
  logic acc;

  assign s1_adv   = s1_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !s1_vld_r || s1_adv;
  assign acc      = in_valid && in_ready;

  // shadows
  rcsr_pkg::prv_t prv_r;
  logic [31:0]    mcen_r;
  logic [31:0]    scen_r;
  logic           isa_c_r;
  logic [3:0]     satp_mode_r;
  logic [NUM_REGS-1:0] ent_vld_r;

  // decode at acceptance
  rcsr_pkg::idx_t idx;
  rcsr_pkg::idx_t coff;
  logic           illegal;
  logic           is_cnt;
  logic           is_ext;
  logic           cnt_ok;
  logic           is_epc;
  logic           mem_we;
  logic [63:0]    wval;
  logic [63:0]    ext_val;
  logic [63:0]    cnt_val;
  logic [AW-1:0]  addr;

  assign idx     = in_reg_index;
  assign addr    = idx[AW-1:0];
  assign illegal = ({1'b0, idx} >= (rcsr_pkg::IDX_W + 1)'(NUM_REGS));
  assign is_cnt  = (idx >= rcsr_pkg::R_CYCLE) && (idx <= rcsr_pkg::R_HPM_LAST);
  assign coff    = idx - rcsr_pkg::R_CYCLE;
  assign is_epc  = (idx == rcsr_pkg::R_MEPC) || (idx == rcsr_pkg::R_SEPC);
  assign is_ext  = is_cnt || (idx == rcsr_pkg::R_HARTID) ||
                   (idx == rcsr_pkg::R_IP) || (idx == rcsr_pkg::R_IE);

  always_comb begin
    unique case (prv_r)
      rcsr_pkg::PRV_M: cnt_ok = 1'b1;
      rcsr_pkg::PRV_S: cnt_ok = mcen_r[coff[4:0]];
      rcsr_pkg::PRV_U: cnt_ok = scen_r[coff[4:0]];
      default:         cnt_ok = 1'b0;
    endcase
  end

  always_comb begin
    priority if (idx == rcsr_pkg::R_TIME) begin
      cnt_val = in_wall_time;
    end else if (idx == rcsr_pkg::R_INSTRET) begin
      cnt_val = in_retired_count;
    end else begin
      cnt_val = in_cycle_count;
    end
  end

  always_comb begin
    priority if (idx == rcsr_pkg::R_HARTID) begin
      ext_val = 64'(hart_id_r);
    end else if (idx == rcsr_pkg::R_IP) begin
      ext_val = in_pending_ints;
    end else if (idx == rcsr_pkg::R_IE) begin
      ext_val = in_enabled_ints;
    end else begin
      ext_val = cnt_ok ? cnt_val : '0;
    end
  end

  always_comb begin
    wval = in_write_data;
    unique case (idx)
      rcsr_pkg::R_SATP: begin
        if ((in_write_data[63:60] != rcsr_pkg::SATP_BARE) &&
            (in_write_data[63:60] != rcsr_pkg::SATP_SV39)) begin
          wval[63:60] = satp_mode_r;
        end
      end
      rcsr_pkg::R_TSELECT: wval = in_write_data + 64'd1;
      rcsr_pkg::R_ISA: begin
        if (!in_write_data[rcsr_pkg::EXT_C] && (in_next_pc_low != 2'd0)) begin
          wval[rcsr_pkg::EXT_C] = isa_c_r;
        end
      end
      rcsr_pkg::R_STATUS: wval[35:32] = rcsr_pkg::XL_FIXED;
      default: wval = in_write_data;
    endcase
  end

  assign mem_we = acc && in_action && !illegal && !is_cnt &&
                  (idx != rcsr_pkg::R_IP) && (idx != rcsr_pkg::R_IE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prv_r       <= rcsr_pkg::PRV_M;
      mcen_r      <= rcsr_pkg::CNTEN_RST[31:0];
      scen_r      <= rcsr_pkg::CNTEN_RST[31:0];
      isa_c_r     <= rcsr_pkg::ISA_RST[rcsr_pkg::EXT_C];
      satp_mode_r <= '0;
      ent_vld_r   <= '0;
    end else if (mem_we) begin
      ent_vld_r[addr] <= 1'b1;
      unique case (idx)
        rcsr_pkg::R_PRV: begin
          priority if (wval == 64'(rcsr_pkg::PRV_M)) begin
            prv_r <= rcsr_pkg::PRV_M;
          end else if (wval == 64'(rcsr_pkg::PRV_S)) begin
            prv_r <= rcsr_pkg::PRV_S;
          end else if (wval == 64'(rcsr_pkg::PRV_U)) begin
            prv_r <= rcsr_pkg::PRV_U;
          end else begin
            prv_r <= rcsr_pkg::PRV_X;
          end
        end
        rcsr_pkg::R_MCOUNTEREN: mcen_r      <= wval[31:0];
        rcsr_pkg::R_SCOUNTEREN: scen_r      <= wval[31:0];
        rcsr_pkg::R_ISA:        isa_c_r     <= wval[rcsr_pkg::EXT_C];
        rcsr_pkg::R_SATP:       satp_mode_r <= wval[63:60];
        default:                ;
      endcase
    end
  end

  // storage
  logic [63:0] ram_rdata;

  rcsr_ram #(
    .WIDTH (rcsr_pkg::XLEN),
    .DEPTH (NUM_REGS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (addr),
    .wdata (wval),
    .re    (acc),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  // stage 1
  logic           s1_rd_r;
  logic           s1_mem_r;
  logic           s1_ent_r;
  logic [1:0]     s1_clr_r;
  logic           s1_ill_r;
  logic           s1_pw_r;
  logic           s1_ew_r;
  logic [63:0]    s1_dat_r;
  rcsr_pkg::idx_t s1_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (acc) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_rd_r  <= !in_action && !illegal;
      s1_mem_r <= !is_ext;
      s1_ent_r <= !illegal && ent_vld_r[addr];
      s1_clr_r <= {is_epc && !isa_c_r, is_epc};
      s1_ill_r <= illegal;
      s1_pw_r  <= in_action && !illegal && (idx == rcsr_pkg::R_IP);
      s1_ew_r  <= in_action && !illegal && (idx == rcsr_pkg::R_IE);
      s1_dat_r <= in_action ? in_write_data : ext_val;
      s1_idx_r <= idx;
    end
  end

  // stage 2: result register
  logic [63:0] mem_val;
  logic [63:0] rd_nxt;

  always_comb begin
    mem_val = s1_ent_r ? ram_rdata : rcsr_pkg::rst_val(s1_idx_r);
    mem_val = mem_val & ~{62'd0, s1_clr_r};
    rd_nxt  = '0;
    if (s1_rd_r) begin
      rd_nxt = s1_mem_r ? mem_val : s1_dat_r;
    end
  end

  logic [63:0] out_rd_r;
  logic        out_ill_r;
  logic        out_pw_r;
  logic        out_ew_r;
  logic [63:0] out_fwd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_rd_r  <= rd_nxt;
      out_ill_r <= s1_ill_r;
      out_pw_r  <= s1_pw_r;
      out_ew_r  <= s1_ew_r;
      out_fwd_r <= (s1_pw_r || s1_ew_r) ? s1_dat_r : '0;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_read_data     = out_rd_r;
  assign out_illegal_index = out_ill_r;
  assign out_pending_write = out_pw_r;
  assign out_enable_write  = out_ew_r;
  assign out_forward_data  = out_fwd_r;

endmodule
`default_nettype wire

@@ sv/rcsr_chk.sv @@
// Port-level checker for the CSR file, bound to the top level.
`default_nettype none
module rcsr_chk (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [63:0] out_read_data,
  input wire logic        out_illegal_index,
  input wire logic        out_pending_write,
  input wire logic        out_enable_write,
  input wire logic [63:0] out_forward_data,
  input wire logic        cfg_pready
);

  a_ill_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_illegal_index |->
      out_read_data == 64'd0 && out_forward_data == 64'd0 &&
      !out_pending_write && !out_enable_write)
    else $error("illegal index word carries data");

  a_fwd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_pending_write || out_enable_write) |->
      !(out_pending_write && out_enable_write) && out_read_data == 64'd0)
    else $error("forwarded write word malformed");

  a_fwd_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_pending_write && !out_enable_write |->
      out_forward_data == 64'd0)
    else $error("forward data without a forwarded write");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data))
    else $error("result word dropped while stalled");

  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("pready low");

endmodule

bind riscv_csr_register_file rcsr_chk u_rcsr_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_read_data     (out_read_data),
  .out_illegal_index (out_illegal_index),
  .out_pending_write (out_pending_write),
  .out_enable_write  (out_enable_write),
  .out_forward_data  (out_forward_data),
  .cfg_pready        (cfg_pready)
);
`default_nettype wire

@@ sim/riscv_csr_register_file_tb.sv @@
// Self-checking testbench for the RV64 CSR file: directed and random accesses against a predictor.
module riscv_csr_register_file_tb;

  localparam int   WATCHDOG_LIMIT = 4000;
  localparam int   LONG_HOLD      = 300;
  localparam rcsr_pkg::idx_t R_UEPC = 7'd114;
  localparam logic [rcsr_pkg::CFG_AW-1:0] HART_ID_ADDR = {rcsr_pkg::CFG_HART_ID, 2'b00};

  typedef enum logic {OP_READ = 1'b0, OP_WRITE = 1'b1} csr_op_t;

  typedef struct packed {
    csr_op_t          op;
    rcsr_pkg::idx_t   idx;
    rcsr_pkg::xword_t wdata;
    rcsr_pkg::xword_t cycles;
    rcsr_pkg::xword_t retired;
    rcsr_pkg::xword_t wall;
    rcsr_pkg::xword_t pend;
    rcsr_pkg::xword_t enab;
    logic [1:0]       npc;
  } csr_access_t;

  typedef struct packed {
    rcsr_pkg::xword_t rdata;
    logic             illegal;
    logic             ip_wr;
    logic             ie_wr;
    rcsr_pkg::xword_t fwd;
  } csr_result_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        in_valid = 1'b0;
  wire                         in_ready;
  logic                        in_action = 1'b0;
  rcsr_pkg::idx_t              in_reg_index = '0;
  rcsr_pkg::xword_t            in_write_data = '0;
  rcsr_pkg::xword_t            in_cycle_count = '0;
  rcsr_pkg::xword_t            in_retired_count = '0;
  rcsr_pkg::xword_t            in_wall_time = '0;
  rcsr_pkg::xword_t            in_pending_ints = '0;
  rcsr_pkg::xword_t            in_enabled_ints = '0;
  logic [1:0]                  in_next_pc_low = '0;
  wire                         out_valid;
  logic                        out_ready = 1'b0;
  wire [63:0]                  out_read_data;
  wire                         out_illegal_index;
  wire                         out_pending_write;
  wire                         out_enable_write;
  wire [63:0]                  out_forward_data;
  logic                        cfg_psel = 1'b0;
  logic                        cfg_penable = 1'b0;
  logic                        cfg_pwrite = 1'b0;
  logic [rcsr_pkg::CFG_AW-1:0] cfg_paddr = '0;
  logic [rcsr_pkg::CFG_DW-1:0] cfg_pwdata = '0;
  wire [rcsr_pkg::CFG_DW-1:0]  cfg_prdata;
  wire                         cfg_pready;

  riscv_csr_register_file dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_action        (in_action),
    .in_reg_index     (in_reg_index),
    .in_write_data    (in_write_data),
    .in_cycle_count   (in_cycle_count),
    .in_retired_count (in_retired_count),
    .in_wall_time     (in_wall_time),
    .in_pending_ints  (in_pending_ints),
    .in_enabled_ints  (in_enabled_ints),
    .in_next_pc_low   (in_next_pc_low),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_read_data    (out_read_data),
    .out_illegal_index(out_illegal_index),
    .out_pending_write(out_pending_write),
    .out_enable_write (out_enable_write),
    .out_forward_data (out_forward_data),
    .cfg_psel         (cfg_psel),
    .cfg_penable      (cfg_penable),
    .cfg_pwrite       (cfg_pwrite),
    .cfg_paddr        (cfg_paddr),
    .cfg_pwdata       (cfg_pwdata),
    .cfg_prdata       (cfg_prdata),
    .cfg_pready       (cfg_pready)
  );

  always #4 clk = ~clk;

  rcsr_pkg::xword_t            csr_shadow [rcsr_pkg::NUM_REGS_DEF];
  logic [rcsr_pkg::HART_W-1:0] hart_id_shadow = '0;
  csr_access_t                 access_q[$];
  csr_result_t                 expected_results[$];
  csr_access_t                 on_bus;
  bit                          src_gaps_on = 1'b1;
  bit                          dst_gaps_on = 1'b1;
  int                          long_hold_req = 0;
  int                          long_hold_seen = 0;
  int                          src_gap = 0;
  int                          dst_stall = 0;
  int                          quiet_cycles = 0;
  int                          mismatches = 0;
  int                          n_reads = 0;
  int                          n_writes = 0;
  int                          n_illegal = 0;
  int                          n_denied = 0;
  int                          n_hart_cfg = 0;

  function automatic rcsr_pkg::xword_t rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic rcsr_pkg::xword_t rand_count();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return rand64();
  endfunction

  // mostly back to back, now and then a long gap
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic csr_access_t make_access(csr_op_t op, rcsr_pkg::idx_t idx,
                                              rcsr_pkg::xword_t wdata, logic [1:0] npc);
    csr_access_t a;
    a.op      = op;
    a.idx     = idx;
    a.wdata   = wdata;
    a.cycles  = rand_count();
    a.retired = rand_count();
    a.wall    = rand_count();
    a.pend    = rand_count();
    a.enab    = rand_count();
    a.npc     = npc;
    return a;
  endfunction

  function automatic csr_access_t random_access();
    csr_op_t          op;
    rcsr_pkg::idx_t   idx;
    rcsr_pkg::xword_t d;
    int               sel;
    op  = csr_op_t'($urandom_range(0, 1));
    d   = rand_count();
    sel = $urandom_range(0, 99);
    if (sel < 8) begin
      idx = rcsr_pkg::idx_t'($urandom_range(rcsr_pkg::NUM_REGS_DEF, 127));
    end else if (sel < 20) begin
      op  = OP_WRITE;
      idx = rcsr_pkg::R_PRV;
      if ($urandom_range(0, 9) != 0) d = rcsr_pkg::xword_t'($urandom_range(0, 3));
    end else if (sel < 28) begin
      op  = OP_WRITE;
      idx = $urandom_range(0, 1) ? rcsr_pkg::R_MCOUNTEREN : rcsr_pkg::R_SCOUNTEREN;
    end else if (sel < 50) begin
      op  = OP_READ;
      idx = rcsr_pkg::idx_t'($urandom_range(rcsr_pkg::R_CYCLE, rcsr_pkg::R_HPM_LAST));
    end else if (sel < 58) begin
      case ($urandom_range(0, 2))
        0: idx = rcsr_pkg::R_HARTID;
        1: idx = rcsr_pkg::R_IP;
        default: idx = rcsr_pkg::R_IE;
      endcase
    end else if (sel < 74) begin
      case ($urandom_range(0, 6))
        0: idx = rcsr_pkg::R_ISA;
        1: idx = rcsr_pkg::R_STATUS;
        2: idx = rcsr_pkg::R_TSELECT;
        3: idx = rcsr_pkg::R_SATP;
        4: idx = rcsr_pkg::R_MEPC;
        5: idx = rcsr_pkg::R_SEPC;
        default: idx = R_UEPC;
      endcase
      if (idx == rcsr_pkg::R_SATP && $urandom_range(0, 1))
        d[63:60] = $urandom_range(0, 1) ? rcsr_pkg::SATP_BARE : rcsr_pkg::SATP_SV39;
    end else begin
      idx = rcsr_pkg::idx_t'($urandom_range(0, rcsr_pkg::NUM_REGS_DEF - 1));
    end
    return make_access(op, idx, d, 2'($urandom_range(0, 3)));
  endfunction

  function automatic bit counter_open(rcsr_pkg::idx_t idx);
    logic [4:0]       bit_sel;
    rcsr_pkg::xword_t prv;
    rcsr_pkg::xword_t en;
    bit_sel = 5'(idx - rcsr_pkg::R_CYCLE);
    prv     = csr_shadow[rcsr_pkg::R_PRV];
    if (prv == 64'(rcsr_pkg::PRV_M)) return 1'b1;
    if (prv == 64'(rcsr_pkg::PRV_S)) en = csr_shadow[rcsr_pkg::R_MCOUNTEREN];
    else if (prv == 64'(rcsr_pkg::PRV_U)) en = csr_shadow[rcsr_pkg::R_SCOUNTEREN];
    else return 1'b0;
    return en[bit_sel];
  endfunction

  // expected result of one access; updates the shadow file on writes
  function automatic csr_result_t predict_access(csr_access_t a);
    csr_result_t      r;
    rcsr_pkg::xword_t v;
    rcsr_pkg::xword_t old;
    r = '0;
    if (a.idx >= rcsr_pkg::idx_t'(rcsr_pkg::NUM_REGS_DEF)) begin
      r.illegal = 1'b1;
      n_illegal++;
      return r;
    end
    if (a.op == OP_READ) begin
      n_reads++;
      if (a.idx == rcsr_pkg::R_HARTID) begin
        r.rdata = rcsr_pkg::xword_t'(hart_id_shadow);
      end else if (a.idx == rcsr_pkg::R_IP) begin
        r.rdata = a.pend;
      end else if (a.idx == rcsr_pkg::R_IE) begin
        r.rdata = a.enab;
      end else if (a.idx >= rcsr_pkg::R_CYCLE && a.idx <= rcsr_pkg::R_HPM_LAST) begin
        if (!counter_open(a.idx)) n_denied++;
        else if (a.idx == rcsr_pkg::R_TIME) r.rdata = a.wall;
        else if (a.idx == rcsr_pkg::R_INSTRET) r.rdata = a.retired;
        else r.rdata = a.cycles;
      end else begin
        r.rdata = csr_shadow[a.idx];
        if (a.idx == rcsr_pkg::R_MEPC || a.idx == rcsr_pkg::R_SEPC) begin
          r.rdata[0] = 1'b0;
          if (!csr_shadow[rcsr_pkg::R_ISA][rcsr_pkg::EXT_C]) r.rdata[1] = 1'b0;
        end
      end
      return r;
    end
    n_writes++;
    v   = a.wdata;
    old = csr_shadow[a.idx];
    if (a.idx == rcsr_pkg::R_IP) begin
      r.ip_wr = 1'b1;
      r.fwd   = v;
    end else if (a.idx == rcsr_pkg::R_IE) begin
      r.ie_wr = 1'b1;
      r.fwd   = v;
    end else if (!(a.idx >= rcsr_pkg::R_CYCLE && a.idx <= rcsr_pkg::R_HPM_LAST)) begin
      case (a.idx)
        rcsr_pkg::R_SATP: begin
          if (v[63:60] != rcsr_pkg::SATP_BARE && v[63:60] != rcsr_pkg::SATP_SV39)
            v[63:60] = old[63:60];
        end
        rcsr_pkg::R_TSELECT: v = v + 64'd1;
        rcsr_pkg::R_ISA: begin
          if (!v[rcsr_pkg::EXT_C] && a.npc != 2'd0)
            v[rcsr_pkg::EXT_C] = old[rcsr_pkg::EXT_C];
        end
        rcsr_pkg::R_STATUS: v[35:32] = old[35:32];
        default: ;
      endcase
      csr_shadow[a.idx] = v;
    end
    return r;
  endfunction

  task automatic check_field(input string name, input rcsr_pkg::xword_t want,
                             input rcsr_pkg::xword_t got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endtask

  task automatic queue_access(input csr_op_t op, input rcsr_pkg::idx_t idx,
                              input rcsr_pkg::xword_t d, input logic [1:0] npc);
    access_q.push_back(make_access(op, idx, d, npc));
  endtask

  task automatic set_hart_id(input logic [rcsr_pkg::CFG_DW-1:0] raw);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= HART_ID_ADDR;
    cfg_pwdata  <= raw;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    hart_id_shadow = raw[rcsr_pkg::HART_W-1:0];
    n_hart_cfg++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (access_q.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // access driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      src_gap = 0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(predict_access(on_bus));
      if (!in_valid || in_ready) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (access_q.size() != 0) begin
          on_bus = access_q.pop_front();
          in_action        <= on_bus.op;
          in_reg_index     <= on_bus.idx;
          in_write_data    <= on_bus.wdata;
          in_cycle_count   <= on_bus.cycles;
          in_retired_count <= on_bus.retired;
          in_wall_time     <= on_bus.wall;
          in_pending_ints  <= on_bus.pend;
          in_enabled_ints  <= on_bus.enab;
          in_next_pc_low   <= on_bus.npc;
          in_valid         <= 1'b1;
          src_gap = src_gaps_on ? idle_len() : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver back-pressure
  always @(posedge clk) begin : result_monitor
    csr_result_t got;
    csr_result_t want;
    int          n;
    if (!rst_n) begin
      out_ready <= 1'b0;
      dst_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.rdata   = out_read_data;
        got.illegal = out_illegal_index;
        got.ip_wr   = out_pending_write;
        got.ie_wr   = out_enable_write;
        got.fwd     = out_forward_data;
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word, expected none got %h", $time, got);
        end else begin
          want = expected_results.pop_front();
          check_field("read_data", want.rdata, got.rdata);
          check_field("illegal_index", rcsr_pkg::xword_t'(want.illegal),
                      rcsr_pkg::xword_t'(got.illegal));
          check_field("pending_write", rcsr_pkg::xword_t'(want.ip_wr),
                      rcsr_pkg::xword_t'(got.ip_wr));
          check_field("enable_write", rcsr_pkg::xword_t'(want.ie_wr),
                      rcsr_pkg::xword_t'(got.ie_wr));
          check_field("forward_data", want.fwd, got.fwd);
        end
      end
      if (long_hold_req != long_hold_seen) begin
        long_hold_seen = long_hold_req;
        dst_stall = LONG_HOLD;
      end
      if (dst_stall > 0) begin
        dst_stall--;
        out_ready <= 1'b0;
      end else begin
        n = dst_gaps_on ? idle_len() : 0;
        if (n > 0) begin
          dst_stall = n - 1;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_psel && cfg_penable))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, quiet_cycles);
        $display("FAIL riscv_csr_register_file");
        $finish;
      end
    end
  end

  initial begin : stimulus
    foreach (csr_shadow[i]) csr_shadow[i] = '0;
    csr_shadow[rcsr_pkg::R_PRV]        = 64'h3;
    csr_shadow[rcsr_pkg::R_ISA]        = 64'h8000_0000_0014_112D;
    csr_shadow[rcsr_pkg::R_STATUS]     = 64'h0000_000A_0000_2000;
    csr_shadow[rcsr_pkg::R_MCOUNTEREN] = 64'h7;
    csr_shadow[rcsr_pkg::R_SCOUNTEREN] = 64'h7;
    csr_shadow[rcsr_pkg::R_TSELECT]    = 64'h1;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset values, forwarding, write rules, EPC masking, counter gating, bad index
    queue_access(OP_READ,  rcsr_pkg::R_PRV,        '0, 2'd0);
    queue_access(OP_READ,  rcsr_pkg::R_ISA,        '0, 2'd0);
    queue_access(OP_READ,  rcsr_pkg::R_STATUS,     '0, 2'd0);
    queue_access(OP_READ,  rcsr_pkg::R_HARTID,     '0, 2'd0);
    queue_access(OP_READ,  rcsr_pkg::R_CYCLE,      '0, 2'd0);
    queue_access(OP_READ,  rcsr_pkg::R_TIME,       '0, 2'd0);
    queue_access(OP_READ,  rcsr_pkg::R_INSTRET,    '0, 2'd0);
    queue_access(OP_WRITE, rcsr_pkg::R_IP,         '1, 2'd3);
    queue_access(OP_WRITE, rcsr_pkg::R_IE,         64'hA5A5_5A5A_0F0F_F0F0, 2'd0);
    queue_access(OP_WRITE, rcsr_pkg::R_CYCLE,      '1, 2'd0);
    queue_access(OP_WRITE, rcsr_pkg::R_TSELECT,    '1, 2'd0);
    queue_access(OP_READ,  rcsr_pkg::R_TSELECT,    '0, 2'd0);
    queue_access(OP_WRITE, rcsr_pkg::R_SATP,       64'h5123_4567_89AB_CDEF, 2'd0);
    queue_access(OP_WRITE, rcsr_pkg::R_SATP,       64'h8000_0000_0000_1234, 2'd0);
    queue_access(OP_WRITE, rcsr_pkg::R_SATP,       64'hF000_0000_0000_0001, 2'd0);
    queue_access(OP_READ,  rcsr_pkg::R_SATP,       '0, 2'd0);
    queue_access(OP_WRITE, rcsr_pkg::R_STATUS,     '1, 2'd0);
    queue_access(OP_READ,  rcsr_pkg::R_STATUS,     '0, 2'd0);
    queue_access(OP_WRITE, rcsr_pkg::R_MEPC,       '1, 2'd0);
    queue_access(OP_WRITE, rcsr_pkg::R_ISA,        '0, 2'd2);
    queue_access(OP_READ,  rcsr_pkg::R_MEPC,       '0, 2'd0);
    queue_access(OP_WRITE, rcsr_pkg::R_ISA,        '0, 2'd0);
    queue_access(OP_READ,  rcsr_pkg::R_MEPC,       '0, 2'd0);
    queue_access(OP_WRITE, rcsr_pkg::R_SCOUNTEREN, 64'h8000_0001, 2'd0);
    queue_access(OP_WRITE, rcsr_pkg::R_PRV,        64'(rcsr_pkg::PRV_U), 2'd0);
    queue_access(OP_READ,  rcsr_pkg::R_HPM_LAST,   '0, 2'd0);
    queue_access(OP_READ,  rcsr_pkg::R_TIME,       '0, 2'd0);
    queue_access(OP_WRITE, rcsr_pkg::R_PRV,        64'(rcsr_pkg::PRV_X), 2'd0);
    queue_access(OP_READ,  rcsr_pkg::R_CYCLE,      '0, 2'd0);
    queue_access(OP_WRITE, rcsr_pkg::R_PRV,        64'(rcsr_pkg::PRV_S), 2'd0);
    queue_access(OP_READ,  rcsr_pkg::R_INSTRET,    '0, 2'd0);
    queue_access(OP_READ,  rcsr_pkg::idx_t'(rcsr_pkg::NUM_REGS_DEF), '0, 2'd0);
    queue_access(OP_WRITE, 7'h7F,                  '1, 2'd1);
    queue_access(OP_WRITE, rcsr_pkg::R_PRV,        64'(rcsr_pkg::PRV_M), 2'd0);
    wait_drained();

    set_hart_id(32'hFFFF_FFFF);
    repeat (500) access_q.push_back(random_access());
    wait_drained();

    // receiver holds off while the sender keeps offering words
    set_hart_id(32'h0000_F000);
    src_gaps_on = 1'b0;
    long_hold_req++;
    repeat (80) access_q.push_back(random_access());
    wait_drained();

    set_hart_id($urandom);
    dst_gaps_on = 1'b0;
    repeat (400) access_q.push_back(random_access());
    wait_drained();

    set_hart_id($urandom);
    src_gaps_on = 1'b1;
    dst_gaps_on = 1'b1;
    repeat (800) access_q.push_back(random_access());
    wait_drained();
    repeat (8) @(negedge clk);

    $display("covered %0d reads (%0d counter reads denied), %0d writes, %0d out-of-range",
             n_reads, n_denied, n_writes, n_illegal);
    $display("hart id set %0d times, %0d mismatches", n_hart_cfg, mismatches);
    if (mismatches == 0) begin
      $display("PASS riscv_csr_register_file");
    end else begin
      $display("FAIL riscv_csr_register_file");
    end
    $finish;
  end

endmodule
